// ===== hdl/pil_pkg.sv =====
// Shared types and constants for the positional insert list.
package pil_pkg;

  localparam int DATA_W = 32;
  localparam int CNT_W  = 7;

  typedef enum logic [1:0] {
    FN_INS_FRONT = 2'd0,
    FN_INS_BACK  = 2'd1,
    FN_INS_POS   = 2'd2,
    FN_READ_ALL  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_BOUND = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_EMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_ROTATE = 2'd2
  } cell_op_t;

  typedef struct packed {
    cell_op_t                  op;
    logic [CNT_W-1:0]          pos;
    logic [CNT_W-1:0]          last;
    logic signed [DATA_W-1:0]  value;
    logic signed [DATA_W-1:0]  head;
  } cell_ctrl_t;

endpackage

// ===== hdl/positional_insert_list.sv =====
// Top level of the positional insert list: control, count and the cell chain.
//
// Usage: a transaction is accepted at a rising edge where start is high and
// busy is low. func selects insert at front, insert at back, insert at
// position, or read out the whole list; value and position go with it.
// Results appear on status, entry_value, entry_index and last for exactly
// one cycle, marked by valid; the receiver cannot stall them.
// An insert gives one result in the cycle after acceptance, and busy stays
// low, so inserts may be issued in every cycle. The insert moves all cells
// of the chain in parallel as it is accepted. A readout of N entries keeps
// busy high until its final entry is registered and gives one result per
// cycle: the state register first enters the read state, then the output
// registers take the head cell; the final result is marked by last. Each
// readout cycle rotates the stored entries by one cell, so the list is
// back in order when the readout ends. An empty list gives one result with
// the empty status in the cycle after acceptance.
// Reset empties the list; the stored entries themselves are not cleared.
module positional_insert_list import pil_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               func,
  input  logic signed [31:0]       value,
  input  logic [5:0]               position,
  output logic                     valid,
  output logic [1:0]               status,
  output logic signed [31:0]       entry_value,
  output logic [5:0]               entry_index,
  output logic                     last
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int RW = $clog2(DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_t;

  state_t                   state;
  logic [CW-1:0]            count;
  logic [RW-1:0]            rd_idx;
  logic [CNT_W-1:0]         ins_pos;
  status_t                  ins_status;
  logic                     is_last;
  logic                     accept;
  cell_ctrl_t               ctrl;
  logic signed [DATA_W-1:0] cell_data [DEPTH];

  assign busy   = (state == ST_READ);
  assign accept = start && !busy;

  always_comb begin
    case (func_t'(func))
      FN_INS_FRONT: ins_pos = '0;
      FN_INS_BACK:  ins_pos = CNT_W'(count);
      default:      ins_pos = CNT_W'(position);
    endcase
    if (ins_pos > CNT_W'(count)) begin
      ins_status = STAT_BOUND;
    end else if (count == CW'(DEPTH)) begin
      ins_status = STAT_FULL;
    end else begin
      ins_status = STAT_OK;
    end
  end

  assign is_last = (CNT_W'(rd_idx) == ctrl.last);

  always_comb begin
    ctrl.op    = CELL_HOLD;
    ctrl.pos   = ins_pos;
    ctrl.last  = CNT_W'(count) - CNT_W'(1);
    ctrl.value = value;
    ctrl.head  = cell_data[0];
    if (state == ST_READ) begin
      ctrl.op = CELL_ROTATE;
    end else if (accept && func_t'(func) != FN_READ_ALL && ins_status == STAT_OK) begin
      ctrl.op = CELL_INSERT;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_data;
    logic signed [DATA_W-1:0] right_data;
    if (i == 0) begin : g_first
      assign left_data = '0;
    end else begin : g_mid_l
      assign left_data = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_final
      assign right_data = '0;
    end else begin : g_mid_r
      assign right_data = cell_data[i+1];
    end
    pil_cell u_cell (
      .clk   (clk),
      .index (CNT_W'(i)),
      .ctrl  (ctrl),
      .left  (left_data),
      .right (right_data),
      .data  (cell_data[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      count  <= '0;
      rd_idx <= '0;
      valid  <= 1'b0;
    end else begin
      valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            entry_value <= '0;
            entry_index <= '0;
            last        <= 1'b1;
            if (func_t'(func) == FN_READ_ALL) begin
              if (count == '0) begin
                valid  <= 1'b1;
                status <= STAT_EMPTY;
              end else begin
                state  <= ST_READ;
                rd_idx <= '0;
              end
            end else begin
              valid  <= 1'b1;
              status <= ins_status;
              if (ins_status == STAT_OK) begin
                count <= count + CW'(1);
              end
            end
          end
        end
        ST_READ: begin
          valid       <= 1'b1;
          status      <= STAT_OK;
          entry_value <= cell_data[0];
          entry_index <= 6'(rd_idx);
          last        <= is_last;
          rd_idx      <= rd_idx + RW'(1);
          if (is_last) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("count exceeds depth");

  a_insert_result: assert property (@(posedge clk) disable iff (rst)
    (accept && func_t'(func) != FN_READ_ALL) |=> (valid && last))
    else $error("insert transaction gave no single result");

  a_read_stream: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |=> (valid && status == STAT_OK))
    else $error("readout cycle gave no entry result");

  a_empty_clean: assert property (@(posedge clk) disable iff (rst)
    (valid && status == STAT_EMPTY) |-> (entry_value == '0 && last))
    else $error("empty result malformed");

endmodule

// ===== hdl/pil_cell.sv =====
// One list cell: holds one entry and moves it with its neighbors.
module pil_cell import pil_pkg::*; (
  input  logic                     clk,
  input  logic [CNT_W-1:0]         index,
  input  cell_ctrl_t               ctrl,
  input  logic signed [DATA_W-1:0] left,
  input  logic signed [DATA_W-1:0] right,
  output logic signed [DATA_W-1:0] data
);

  logic signed [DATA_W-1:0] data_next;

  always_comb begin
    data_next = data;
    case (ctrl.op)
      CELL_INSERT: begin
        if (index > ctrl.pos) begin
          data_next = left;
        end else if (index == ctrl.pos) begin
          data_next = ctrl.value;
        end
      end
      CELL_ROTATE: begin
        if (index < ctrl.last) begin
          data_next = right;
        end else if (index == ctrl.last) begin
          data_next = ctrl.head;
        end
      end
      default: begin
        data_next = data;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the positional insert list with random command bursts.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pil_pkg::*;

  localparam int LIST_DEPTH  = 32;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 2 * LIST_DEPTH + 8;
  localparam int RANDOM_CMDS = 100;

  typedef struct {
    func_t             fn;
    logic signed [31:0] val;
    logic [5:0]        pos;
  } list_cmd_t;

  typedef struct {
    status_t            stat;
    logic signed [31:0] val;
    logic [5:0]         idx;
    logic               fin;
  } list_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         func = FN_INS_FRONT;
  logic signed [31:0] value = '0;
  logic [5:0]         position = '0;
  logic               valid;
  logic [1:0]         status;
  logic signed [31:0] entry_value;
  logic [5:0]         entry_index;
  logic               last;

  list_cmd_t          pending_cmds[$];
  list_result_t       expected_results[$];
  logic signed [31:0] shadow_list[$];
  int                 gen_count = 0;
  int                 error_count = 0;
  int                 cycle_count = 0;
  int                 burst_left = 6;
  int                 gap_left = 0;

  positional_insert_list #(.DEPTH(LIST_DEPTH)) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .func(func),
    .value(value),
    .position(position),
    .valid(valid),
    .status(status),
    .entry_value(entry_value),
    .entry_index(entry_index),
    .last(last)
  );

  always #6 clk = ~clk;

  function automatic int insert_slot(func_t fn, logic [5:0] pos, int cnt);
    case (fn)
      FN_INS_FRONT: return 0;
      FN_INS_BACK:  return cnt;
      default:      return int'(pos);
    endcase
  endfunction

  task automatic predict_list_op(list_cmd_t cmd);
    list_result_t r;
    int           slot;
    int           n;
    r.stat = STAT_OK;
    r.val  = '0;
    r.idx  = '0;
    r.fin  = 1'b1;
    n = shadow_list.size();
    if (cmd.fn == FN_READ_ALL) begin
      if (n == 0) begin
        r.stat = STAT_EMPTY;
        expected_results.push_back(r);
      end else begin
        for (int i = 0; i < n; i++) begin
          r.val = shadow_list[i];
          r.idx = i[5:0];
          r.fin = (i == n - 1);
          expected_results.push_back(r);
        end
      end
    end else begin
      slot = insert_slot(cmd.fn, cmd.pos, n);
      if (slot > n) begin
        r.stat = STAT_BOUND;
      end else if (n >= LIST_DEPTH) begin
        r.stat = STAT_FULL;
      end else begin
        shadow_list.insert(slot, cmd.val);
      end
      expected_results.push_back(r);
    end
  endtask

  task automatic queue_cmd(func_t fn, logic signed [31:0] val, logic [5:0] pos);
    list_cmd_t cmd;
    int        slot;
    cmd.fn  = fn;
    cmd.val = val;
    cmd.pos = pos;
    pending_cmds.push_back(cmd);
    if (fn != FN_READ_ALL) begin
      slot = insert_slot(fn, pos, gen_count);
      if (slot <= gen_count && gen_count < LIST_DEPTH) gen_count++;
    end
  endtask

  // Driver: presents queued transactions in bursts and holds each one until it is taken.
  always @(posedge clk) begin
    logic      nxt_start;
    list_cmd_t cmd;
    nxt_start = start;
    cycle_count <= cycle_count + 1;
    if (rst) begin
      nxt_start = 1'b0;
    end else begin
      if (start && !busy) begin
        cmd.fn  = func_t'(func);
        cmd.val = value;
        cmd.pos = position;
        predict_list_op(cmd);
      end
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left--;
          nxt_start = 1'b0;
        end else if (pending_cmds.size() > 0) begin
          cmd = pending_cmds.pop_front();
          func     <= cmd.fn;
          value    <= cmd.val;
          position <= cmd.pos;
          nxt_start = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            gap_left   = $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 10);
          end
        end else begin
          nxt_start = 1'b0;
        end
      end
    end
    start <= nxt_start;
  end

  // Monitor: every strobed result must match the oldest outstanding expectation.
  always @(posedge clk) begin
    list_result_t exp_r;
    if (!rst && valid) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result: status %0d value %0d index %0d last %0b",
                 $time, status, entry_value, entry_index, last);
        error_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (status !== exp_r.stat) begin
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, exp_r.stat, status);
          error_count++;
        end
        if (entry_value !== exp_r.val) begin
          $display("%0t: entry_value mismatch: expected %0d, actual %0d",
                   $time, exp_r.val, entry_value);
          error_count++;
        end
        if (entry_index !== exp_r.idx) begin
          $display("%0t: entry_index mismatch: expected %0d, actual %0d",
                   $time, exp_r.idx, entry_index);
          error_count++;
        end
        if (last !== exp_r.fin) begin
          $display("%0t: last mismatch: expected %0b, actual %0b",
                   $time, exp_r.fin, last);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int sel;
    queue_cmd(FN_READ_ALL, 32'sd0, 6'd0);
    queue_cmd(FN_INS_POS, 32'sd7, 6'd1);
    queue_cmd(FN_INS_POS, 32'sd9, 6'd63);
    queue_cmd(FN_INS_POS, 32'sh8000_0000, 6'd0);
    queue_cmd(FN_INS_FRONT, 32'sh7FFF_FFFF, 6'd0);
    queue_cmd(FN_INS_BACK, -32'sd1, 6'd0);
    queue_cmd(FN_INS_POS, 32'sd0, 6'd3);
    queue_cmd(FN_INS_POS, 32'sd1, 6'd1);
    queue_cmd(FN_INS_FRONT, 32'sd0, 6'd42);
    queue_cmd(FN_INS_BACK, 32'sh5555_5555, 6'd63);
    queue_cmd(FN_INS_POS, 32'shAAAA_AAAA, 6'd7);
    queue_cmd(FN_READ_ALL, 32'shFFFF_FFFF, 6'd63);
    for (int i = 0; i < RANDOM_CMDS; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 15) begin
        queue_cmd(FN_READ_ALL, $urandom, 6'($urandom));
      end else if (sel < 25) begin
        queue_cmd(FN_INS_POS, $urandom, 6'($urandom_range(gen_count + 1, 63)));
      end else if (sel < 45) begin
        queue_cmd(FN_INS_FRONT, $urandom, 6'($urandom));
      end else if (sel < 65) begin
        queue_cmd(FN_INS_BACK, $urandom, 6'($urandom));
      end else begin
        queue_cmd(FN_INS_POS, $urandom, 6'($urandom_range(0, gen_count)));
      end
    end
    while (gen_count < LIST_DEPTH) queue_cmd(FN_INS_BACK, $urandom, 6'($urandom));
    queue_cmd(FN_INS_POS, $urandom, 6'(gen_count));
    queue_cmd(FN_INS_POS, $urandom, 6'(gen_count + 1));
    queue_cmd(FN_INS_FRONT, $urandom, 6'd0);
    queue_cmd(FN_READ_ALL, $urandom, 6'd0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (pending_cmds.size() > 0 || start || expected_results.size() > 0);
    repeat (DRAIN_WAIT) @(negedge clk);

    if (error_count == 0 && expected_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
